### rtl/dcbar_pkg.sv
// ============================================================================
// dcbar_pkg
// Shared types and constants for the dual-copy bitmap address resolver.
// ============================================================================
package dcbar_pkg;

    // Default bitmap depths in 32-bit words per copy
    localparam int L1_WORDS_DEF = 16;
    localparam int L2_WORDS_DEF = 1024;

    localparam int WORD_W   = 32;
    localparam int POS_W    = 5;
    localparam int OFFSET_W = 34;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;

    // Stream tdata and tuser widths for input and output words
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 1;

    // Level one / level two word index widths after the shifts
    localparam int L1_WORD_IDX_W = 24;
    localparam int L2_WORD_IDX_W = 27;

    // Command codes carried in s_tuser
    typedef enum logic [1:0] {
        CMD_WR_L1   = 2'd0,
        CMD_WR_L2   = 2'd1,
        CMD_RESOLVE = 2'd2
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_L1_COPY_SEL = 3'd0,
        CFG_L2_LOG2     = 3'd1,
        CFG_L1_LOG2     = 3'd2,
        CFG_L3_OFFSET   = 3'd3,
        CFG_L3_SIZE     = 3'd4
    } cfg_idx_t;

    // Bitmap lookup request derived from one byte index
    typedef struct packed {
        logic [L1_WORD_IDX_W-1:0] l1_word;
        logic [L2_WORD_IDX_W-1:0] l2_word;
        logic [POS_W-1:0]         l1_pos;
        logic [POS_W-1:0]         l2_pos;
        logic                     bad;
    } lookup_t;

endpackage

### rtl/dcbar_ram.sv
// ============================================================================
// dcbar_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module dcbar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;
    logic [AW-1:0]    raddr_w;

    assign raddr_w = raddr;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, held while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr_w];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/dcbar_index.sv
// ============================================================================
// dcbar_index
// Turns a byte index into bitmap word addresses, bit positions and range flag.
// ============================================================================
module dcbar_index #(
    parameter int L1_WORDS = dcbar_pkg::L1_WORDS_DEF,
    parameter int L2_WORDS = dcbar_pkg::L2_WORDS_DEF
) (
    input  logic [dcbar_pkg::WORD_W-1:0] byte_index,
    input  logic [dcbar_pkg::POS_W-1:0]  level2_block_log2,
    input  logic [dcbar_pkg::POS_W-1:0]  level1_block_log2,
    input  logic [dcbar_pkg::WORD_W-1:0] level3_size,
    output dcbar_pkg::lookup_t           lookup
);

    logic [31:0] l2_bit;
    logic [28:0] l1_bit;

    // Bit indices by right shifts
    assign l2_bit = byte_index >> level2_block_log2;
    assign l1_bit = l2_bit[31:3] >> level1_block_log2;

    // Word addresses, MSB-first bit positions and range check
    always_comb begin
        lookup.l1_word = l1_bit[28:5];
        lookup.l2_word = l2_bit[31:5];
        lookup.l1_pos  = ~l1_bit[4:0];
        lookup.l2_pos  = ~l2_bit[4:0];
        lookup.bad     = (byte_index >= level3_size) ||
                         (32'(l1_bit[28:5]) >= 32'(L1_WORDS)) ||
                         (32'(l2_bit[31:5]) >= 32'(L2_WORDS));
    end

endmodule

### rtl/dcbar_bitmaps.sv
// ============================================================================
// dcbar_bitmaps
// Two copies each of the level one and level two bitmaps, with word writes
// and a registered lookup that fetches both level two copies at once.
// ============================================================================
module dcbar_bitmaps #(
    parameter int L1_WORDS = dcbar_pkg::L1_WORDS_DEF,
    parameter int L2_WORDS = dcbar_pkg::L2_WORDS_DEF
) (
    input  logic                         aclk,
    input  logic                         wr_fire,
    input  logic [1:0]                   command,
    input  logic                         copy_number,
    input  logic [9:0]                   word_index,
    input  logic [dcbar_pkg::WORD_W-1:0] word_value,
    input  logic                         rd_en,
    input  dcbar_pkg::lookup_t           lookup,
    input  logic                         level1_copy_select,
    output logic [dcbar_pkg::WORD_W-1:0] l1_data,
    output logic [dcbar_pkg::WORD_W-1:0] l2_data0,
    output logic [dcbar_pkg::WORD_W-1:0] l2_data1
);

    localparam int AW1 = (L1_WORDS > 1) ? $clog2(L1_WORDS) : 1;
    localparam int AW2 = (L2_WORDS > 1) ? $clog2(L2_WORDS) : 1;

    logic [31:0]     widx_ext;
    logic            wr_l1;
    logic            wr_l2;
    logic [1:0]      l1_we;
    logic [1:0]      l2_we;
    logic [AW1-1:0]  l1_waddr;
    logic [AW2-1:0]  l2_waddr;
    logic [AW1-1:0]  l1_raddr;
    logic [AW2-1:0]  l2_raddr;
    logic [dcbar_pkg::WORD_W-1:0] l1_rd0;
    logic [dcbar_pkg::WORD_W-1:0] l1_rd1;

    // Decode word writes; drop writes past the stored depth
    assign widx_ext = 32'(word_index);
    assign wr_l1 = wr_fire && (command == dcbar_pkg::CMD_WR_L1) &&
                   (widx_ext < 32'(L1_WORDS));
    assign wr_l2 = wr_fire && (command == dcbar_pkg::CMD_WR_L2) &&
                   (widx_ext < 32'(L2_WORDS));
    assign l1_we = {wr_l1 && copy_number, wr_l1 && !copy_number};
    assign l2_we = {wr_l2 && copy_number, wr_l2 && !copy_number};
    assign l1_waddr = widx_ext[AW1-1:0];
    assign l2_waddr = widx_ext[AW2-1:0];
    assign l1_raddr = lookup.l1_word[AW1-1:0];
    assign l2_raddr = lookup.l2_word[AW2-1:0];

    dcbar_ram #(.WIDTH(dcbar_pkg::WORD_W), .DEPTH(L1_WORDS)) u_l1_copy0 (
        .aclk  (aclk),
        .we    (l1_we[0]),
        .waddr (l1_waddr),
        .wdata (word_value),
        .re    (rd_en),
        .raddr (l1_raddr),
        .rdata (l1_rd0)
    );

    dcbar_ram #(.WIDTH(dcbar_pkg::WORD_W), .DEPTH(L1_WORDS)) u_l1_copy1 (
        .aclk  (aclk),
        .we    (l1_we[1]),
        .waddr (l1_waddr),
        .wdata (word_value),
        .re    (rd_en),
        .raddr (l1_raddr),
        .rdata (l1_rd1)
    );

    dcbar_ram #(.WIDTH(dcbar_pkg::WORD_W), .DEPTH(L2_WORDS)) u_l2_copy0 (
        .aclk  (aclk),
        .we    (l2_we[0]),
        .waddr (l2_waddr),
        .wdata (word_value),
        .re    (rd_en),
        .raddr (l2_raddr),
        .rdata (l2_data0)
    );

    dcbar_ram #(.WIDTH(dcbar_pkg::WORD_W), .DEPTH(L2_WORDS)) u_l2_copy1 (
        .aclk  (aclk),
        .we    (l2_we[1]),
        .waddr (l2_waddr),
        .wdata (word_value),
        .re    (rd_en),
        .raddr (l2_raddr),
        .rdata (l2_data1)
    );

    // Pick the active level one copy
    assign l1_data = level1_copy_select ? l1_rd1 : l1_rd0;

endmodule

### rtl/dual_copy_bitmap_address_resolver_top.sv
// ============================================================================
// dual_copy_bitmap_address_resolver_top
// Resolves a logical level three byte index to a physical partition offset
// through duplicated level one and level two bitmaps.
// ============================================================================
// A resolve word passes the bitmap read register, then the output register.
// Throughput: one word per cycle unless m_tready stalls the output; the
//   registered bitmap read is stage one, bit selection and the offset add
//   are stage two into the output register.
// Reset: aresetn clears the pipeline valids and all configuration registers.
//   Bitmap contents are not cleared and are undefined until written.
module dual_copy_bitmap_address_resolver_top #(
    parameter int L1_WORDS = dcbar_pkg::L1_WORDS_DEF,
    parameter int L2_WORDS = dcbar_pkg::L2_WORDS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port
    input  logic                               cfg_we,
    input  logic [dcbar_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dcbar_pkg::CFG_W-1:0]        cfg_data,
    // Input words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [0] copy_number, [10:1] word_index, [42:11] word_value,
    // [74:43] byte_index, [79:75] zero
    input  logic [dcbar_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] command
    input  logic [dcbar_pkg::S_TUSER_W-1:0]    s_tuser,
    // Result words
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [33:0] physical_offset, [39:34] zero
    output logic [dcbar_pkg::M_TDATA_W-1:0]    m_tdata,
    // [0] out_of_range
    output logic [dcbar_pkg::M_TUSER_W-1:0]    m_tuser
);

    // Configuration registers
    logic        l1_copy_sel_reg;
    logic [4:0]  l2_log2_reg;
    logic [4:0]  l1_log2_reg;
    logic [31:0] l3_offset_reg;
    logic [31:0] l3_size_reg;

    // Input fields
    logic        in_copy;
    logic [9:0]  in_word_index;
    logic [31:0] in_word_value;
    logic [31:0] in_byte_index;
    logic [1:0]  in_command;
    logic        s_fire;
    logic        is_resolve;

    dcbar_pkg::lookup_t lookup;

    // Stage A (bitmap read) registers
    logic        a_valid_reg;
    logic        a_valid_next;
    logic        a_bad_reg;
    logic [4:0]  a_l1_pos_reg;
    logic [4:0]  a_l2_pos_reg;
    logic [32:0] a_base_reg;
    logic        a_ready;

    logic [31:0] l1_data;
    logic [31:0] l2_data0;
    logic [31:0] l2_data1;

    // Output registers
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [33:0] m_offset_reg;
    logic [33:0] m_offset_next;
    logic        m_oor_reg;
    logic        out_ready;

    logic        sel2;
    logic [31:0] l2_word;
    logic        sel3;
    logic [33:0] sum;

    // Unpack the input word
    assign in_copy       = s_tdata[0];
    assign in_word_index = s_tdata[10:1];
    assign in_word_value = s_tdata[42:11];
    assign in_byte_index = s_tdata[74:43];
    assign in_command    = s_tuser[1:0];

    // Handshake: output register frees stage A, stage A frees the input
    assign out_ready  = !m_valid_reg || m_tready;
    assign a_ready    = !a_valid_reg || out_ready;
    assign s_tready   = a_ready;
    assign s_fire     = s_tvalid && a_ready;
    assign is_resolve = (in_command == dcbar_pkg::CMD_RESOLVE);

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_copy_sel_reg <= 1'b0;
            l2_log2_reg     <= '0;
            l1_log2_reg     <= '0;
            l3_offset_reg   <= '0;
            l3_size_reg     <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                dcbar_pkg::CFG_L1_COPY_SEL: l1_copy_sel_reg <= cfg_data[0];
                dcbar_pkg::CFG_L2_LOG2:     l2_log2_reg     <= cfg_data[4:0];
                dcbar_pkg::CFG_L1_LOG2:     l1_log2_reg     <= cfg_data[4:0];
                dcbar_pkg::CFG_L3_OFFSET:   l3_offset_reg   <= cfg_data[31:0];
                dcbar_pkg::CFG_L3_SIZE:     l3_size_reg     <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    dcbar_index #(.L1_WORDS(L1_WORDS), .L2_WORDS(L2_WORDS)) u_index (
        .byte_index        (in_byte_index),
        .level2_block_log2 (l2_log2_reg),
        .level1_block_log2 (l1_log2_reg),
        .level3_size       (l3_size_reg),
        .lookup            (lookup)
    );

    dcbar_bitmaps #(.L1_WORDS(L1_WORDS), .L2_WORDS(L2_WORDS)) u_bitmaps (
        .aclk               (aclk),
        .wr_fire            (s_fire),
        .command            (in_command),
        .copy_number        (in_copy),
        .word_index         (in_word_index),
        .word_value         (in_word_value),
        .rd_en              (s_fire),
        .lookup             (lookup),
        .level1_copy_select (l1_copy_sel_reg),
        .l1_data            (l1_data),
        .l2_data0           (l2_data0),
        .l2_data1           (l2_data1)
    );

    // Stage A: only resolve words occupy the pipeline
    assign a_valid_next = a_ready ? (s_fire && is_resolve) : a_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    // Hold lookup details alongside the bitmap read
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_bad_reg    <= lookup.bad;
            a_l1_pos_reg <= lookup.l1_pos;
            a_l2_pos_reg <= lookup.l2_pos;
            a_base_reg   <= 33'(l3_offset_reg) + 33'(in_byte_index);
        end
    end

    // Stage B: walk the copy choices and form the offset
    always_comb begin
        sel2          = l1_data[a_l1_pos_reg];
        l2_word       = sel2 ? l2_data1 : l2_data0;
        sel3          = l2_word[a_l2_pos_reg];
        sum           = 34'(a_base_reg) + (sel3 ? 34'(l3_size_reg) : 34'd0);
        m_offset_next = a_bad_reg ? 34'd0 : sum;
        m_valid_next  = out_ready ? a_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Load the result word when the output register advances
    always_ff @(posedge aclk) begin
        if (out_ready && a_valid_reg) begin
            m_offset_reg <= m_offset_next;
            m_oor_reg    <= a_bad_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_offset_reg};
    assign m_tuser  = m_oor_reg;

    // An out-of-range result carries a zero offset
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[33:0] == 34'd0)
        else $error("out-of-range result with nonzero offset");

    // A full stage A behind a stalled output blocks new words
    assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while pipeline is full");

    // Bitmap writes never enter the result pipeline
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !is_resolve |=> !a_valid_reg)
        else $error("non-resolve word produced a pipeline entry");

    // A resolve word always occupies stage A in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && is_resolve |=> a_valid_reg)
        else $error("resolve word lost from pipeline");

endmodule
